[hw/rtl/decv_pkg.sv]
// shared types, constants and the divider step for the disk collision velocity core
// no dependencies
package decv_pkg;

    // configuration register word indexes
    localparam logic [0:0] REG_DAMPING = 1'b0;
    localparam logic [15:0] DAMPING_RESET = 16'd29491;

    // unit length in q1.30 and the normal speed limit
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
    localparam logic signed [38:0] VN_MAX = 39'sd4294967295;
    localparam logic signed [38:0] VN_MIN = -39'sd4294967295;
    localparam logic signed [41:0] OUT_MAX = 42'sd2147483647;
    localparam logic signed [41:0] OUT_MIN = -42'sd2147483648;

    localparam int DIV_STEPS = 32;

    typedef struct packed {
        logic signed [31:0] own_pos_x;
        logic signed [31:0] own_pos_y;
        logic signed [31:0] own_vel_x;
        logic signed [31:0] own_vel_y;
        logic signed [31:0] other_pos_x;
        logic signed [31:0] other_pos_y;
        logic signed [31:0] other_vel_x;
        logic signed [31:0] other_vel_y;
        logic [30:0]        center_distance;
        logic [30:0]        own_mass;
        logic [30:0]        partner_mass;
    } req_t;

    typedef struct packed {
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic               degenerate;
    } rsp_t;

    // partial remainder, shifting numerator/quotient word and divisor
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] num;
        logic [31:0] den;
    } div_state_t;

    // velocities and flags that ride alongside the dividers
    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic               neg_x;
        logic               neg_y;
        logic               neg_a;
        logic               ovf_x;
        logic               ovf_y;
        logic               deg;
    } side_t;

    // one restoring division step: quotient bit enters at the low end
    function automatic div_state_t div_step(div_state_t s);
        logic [32:0] t;
        div_state_t  n;
        t = {s.rem, s.num[31]};
        n = s;
        if (t >= {1'b0, s.den})
        begin
            n.rem = 32'(t - {1'b0, s.den});
            n.num = {s.num[30:0], 1'b1};
        end
        else
        begin
            n.rem = t[31:0];
            n.num = {s.num[30:0], 1'b0};
        end
        return n;
    endfunction

endpackage

[hw/rtl/decv_div_lane.sv]
// one lane of the pipelined restoring divider, one quotient bit per stage
// depends on decv_pkg
module decv_div_lane (
    input  logic               clk,
    input  logic               en,
    input  decv_pkg::div_state_t init,
    output logic [31:0]        quo
);
    import decv_pkg::*;

    div_state_t stage_reg [0:DIV_STEPS-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg[0] <= div_step(init);
        end
    end

    for (genvar k = 1; k < DIV_STEPS; k++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stage_reg[k] <= div_step(stage_reg[k-1]);
            end
        end
    end

    assign quo = stage_reg[DIV_STEPS-1].num;

endmodule

[hw/rtl/decv_back.sv]
// projection, elastic exchange, rebuild and damping blend stages
// depends on decv_pkg
module decv_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               vld,
    input  decv_pkg::side_t    side,
    input  logic [31:0]        qx,
    input  logic [31:0]        qy,
    input  logic [31:0]        qa,
    input  logic [31:0]        qb,
    input  logic [15:0]        damping,
    output logic               rsp_valid,
    output decv_pkg::rsp_t     rsp
);
    import decv_pkg::*;

    localparam int NSTG = 10;

    logic [NSTG-1:0] vld_reg;

    // common carry fields
    logic signed [31:0] vx_reg [0:NSTG-2];
    logic signed [31:0] vy_reg [0:NSTG-2];
    logic               deg_reg [0:NSTG-2];

    // stage 0: unit normal and mass fractions
    logic [31:0]        magx, magy;
    logic signed [31:0] unx_reg, uny_reg, a_reg, b_reg, wx0_reg, wy0_reg;

    // stage 1: projection products
    logic signed [63:0] p_vx_unx_reg, p_vy_uny_reg, p_vx_uny_reg, p_vy_unx_reg;
    logic signed [63:0] p_wx_unx_reg, p_wy_uny_reg;
    logic signed [31:0] unx1_reg, uny1_reg, a1_reg, b1_reg;

    // stage 2: projections
    logic signed [64:0] s_v1n, s_v1t, s_v2n;
    logic signed [34:0] v1n_reg, v1t_reg, v2n_reg;
    logic signed [31:0] unx2_reg, uny2_reg, a2_reg, b2_reg;

    // stage 3: exchange products
    logic signed [66:0] pa_reg, pb_reg;
    logic signed [34:0] v1t3_reg;
    logic signed [31:0] unx3_reg, uny3_reg;

    // stage 4: new normal speed
    logic signed [67:0] s_vn;
    logic signed [38:0] vn_sh;
    logic signed [32:0] vn_reg;
    logic signed [34:0] v1t4_reg;
    logic signed [31:0] unx4_reg, uny4_reg;

    // stage 5: rebuild products
    logic signed [66:0] vn_unx_reg, vn_uny_reg, vt_unx_reg, vt_uny_reg;

    // stage 6: elastic vector
    logic signed [67:0] s_ex, s_ey;
    logic signed [37:0] ex_reg, ey_reg;

    // stage 7: difference, stage 8: damping product
    logic signed [38:0] dvx_reg, dvy_reg;
    logic signed [55:0] bx_reg, by_reg;

    // stage 9: blend and saturate
    logic signed [41:0] rx, ry;
    rsp_t               out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx_reg[0]  <= side.vx;
            vy_reg[0]  <= side.vy;
            deg_reg[0] <= side.deg;
        end
    end

    for (genvar k = 1; k < NSTG-1; k++)
    begin : g_carry
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                vx_reg[k]  <= vx_reg[k-1];
                vy_reg[k]  <= vy_reg[k-1];
                deg_reg[k] <= deg_reg[k-1];
            end
        end
    end

    // clamp normal components at one
    always_comb
    begin
        magx = (side.ovf_x || qx > ONE_Q30) ? ONE_Q30 : qx;
        magy = (side.ovf_y || qy > ONE_Q30) ? ONE_Q30 : qy;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unx_reg <= side.neg_x ? -$signed(magx) : $signed(magx);
            uny_reg <= side.neg_y ? -$signed(magy) : $signed(magy);
            a_reg   <= side.neg_a ? -$signed(qa) : $signed(qa);
            b_reg   <= $signed(qb);
            wx0_reg <= side.wx;
            wy0_reg <= side.wy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_vx_unx_reg <= 64'(vx_reg[0]) * 64'(unx_reg);
            p_vy_uny_reg <= 64'(vy_reg[0]) * 64'(uny_reg);
            p_vx_uny_reg <= 64'(vx_reg[0]) * 64'(uny_reg);
            p_vy_unx_reg <= 64'(vy_reg[0]) * 64'(unx_reg);
            p_wx_unx_reg <= 64'(wx0_reg) * 64'(unx_reg);
            p_wy_uny_reg <= 64'(wy0_reg) * 64'(uny_reg);
            unx1_reg     <= unx_reg;
            uny1_reg     <= uny_reg;
            a1_reg       <= a_reg;
            b1_reg       <= b_reg;
        end
    end

    // tangent is the normal turned by +90 degrees
    always_comb
    begin
        s_v1n = 65'(p_vx_unx_reg) + 65'(p_vy_uny_reg);
        s_v1t = 65'(p_vy_unx_reg) - 65'(p_vx_uny_reg);
        s_v2n = 65'(p_wx_unx_reg) + 65'(p_wy_uny_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1n_reg  <= 35'(s_v1n >>> 30);
            v1t_reg  <= 35'(s_v1t >>> 30);
            v2n_reg  <= 35'(s_v2n >>> 30);
            unx2_reg <= unx1_reg;
            uny2_reg <= uny1_reg;
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg   <= 67'(v1n_reg) * 67'(a2_reg);
            pb_reg   <= 67'(v2n_reg) * 67'(b2_reg);
            v1t3_reg <= v1t_reg;
            unx3_reg <= unx2_reg;
            uny3_reg <= uny2_reg;
        end
    end

    always_comb
    begin
        s_vn  = 68'(pa_reg) + 68'(pb_reg);
        vn_sh = 39'(s_vn >>> 29);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (vn_sh > VN_MAX)
            begin
                vn_reg <= 33'(VN_MAX);
            end
            else if (vn_sh < VN_MIN)
            begin
                vn_reg <= 33'(VN_MIN);
            end
            else
            begin
                vn_reg <= 33'(vn_sh);
            end
            v1t4_reg <= v1t3_reg;
            unx4_reg <= unx3_reg;
            uny4_reg <= uny3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vn_unx_reg <= 67'(vn_reg) * 67'(unx4_reg);
            vn_uny_reg <= 67'(vn_reg) * 67'(uny4_reg);
            vt_unx_reg <= 67'(v1t4_reg) * 67'(unx4_reg);
            vt_uny_reg <= 67'(v1t4_reg) * 67'(uny4_reg);
        end
    end

    always_comb
    begin
        s_ex = 68'(vn_unx_reg) - 68'(vt_uny_reg);
        s_ey = 68'(vn_uny_reg) + 68'(vt_unx_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ex_reg  <= 38'(s_ex >>> 30);
            ey_reg  <= 38'(s_ey >>> 30);
            dvx_reg <= 39'(ex_reg) - 39'(vx_reg[6]);
            dvy_reg <= 39'(ey_reg) - 39'(vy_reg[6]);
            bx_reg  <= 56'(dvx_reg) * $signed({40'd0, damping});
            by_reg  <= 56'(dvy_reg) * $signed({40'd0, damping});
        end
    end

    always_comb
    begin
        rx = 42'(vx_reg[8]) + 42'(bx_reg >>> 15);
        ry = 42'(vy_reg[8]) + 42'(by_reg >>> 15);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.degenerate <= deg_reg[8];
            if (deg_reg[8])
            begin
                out_reg.new_vel_x <= vx_reg[8];
                out_reg.new_vel_y <= vy_reg[8];
            end
            else
            begin
                out_reg.new_vel_x <= (rx > OUT_MAX) ? 32'(OUT_MAX) :
                                     (rx < OUT_MIN) ? 32'(OUT_MIN) : 32'(rx);
                out_reg.new_vel_y <= (ry > OUT_MAX) ? 32'(OUT_MAX) :
                                     (ry < OUT_MIN) ? 32'(OUT_MIN) : 32'(ry);
            end
        end
    end

    assign rsp_valid = vld_reg[NSTG-1];
    assign rsp       = out_reg;

endmodule

[hw/rtl/disk_elastic_collision_velocity_core.sv]
// top level of the disk collision velocity core: register port, input stage,
// divider lanes and sideband line; depends on decv_pkg, decv_div_lane, decv_back
//
// usage
// - request channel (req_valid, req_stall, req): one colliding pair per request,
//   positions, velocities, centre distance and masses in q16.16
// - response channel (rsp_valid, rsp_stall, rsp): own velocity after the
//   collision, blended by the damping register, and the degenerate flag
// - apb port: word 0 holds collision_damping (q1.15), reset 29491; write it only
//   while no request is in flight
// - throughput: one request per cycle while rsp_stall holds no waiting response;
//   the pipeline has 1 input stage, 32 divider stages and 10 arithmetic stages
// - the 32 bit-per-stage restoring divider lanes set the depth
// - reset clears all valid bits and loads the damping default
// - when rsp_stall holds a waiting response, the whole pipeline freezes and
//   req_stall rises in the same cycle; nothing is dropped or repeated
module disk_elastic_collision_velocity_core (
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               req_valid,
    output logic               req_stall,
    input  decv_pkg::req_t     req,
    // response channel
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output decv_pkg::rsp_t     rsp,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import decv_pkg::*;

    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [31:0] dm;
        logic [30:0]        m2;
        logic [31:0]        msum;
        logic [30:0]        span;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic               deg;
    } s1_t;

    logic        en;
    logic [15:0] damping_reg;

    s1_t         s1_reg;
    logic        s1_vld_reg;

    logic [32:0] mag_x, mag_y;
    logic [30:0] mag_a;
    div_state_t  init_x, init_y, init_a, init_b;
    logic [31:0] qx, qy, qa, qb;
    side_t       side_in;

    side_t                side_reg [0:DIV_STEPS-1];
    logic [DIV_STEPS-1:0] vld_reg;

    // global advance: freeze only while a finished response is held
    assign en        = ~(rsp_valid & rsp_stall);
    assign req_stall = ~en;

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DAMPING) ? {16'd0, damping_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            damping_reg <= DAMPING_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_DAMPING)
        begin
            damping_reg <= pwdata[15:0];
        end
    end

    // input stage: offsets, mass sum and difference
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg.dx   <= 33'(req.other_pos_x) - 33'(req.own_pos_x);
            s1_reg.dy   <= 33'(req.other_pos_y) - 33'(req.own_pos_y);
            s1_reg.dm   <= $signed({1'b0, req.own_mass}) - $signed({1'b0, req.partner_mass});
            s1_reg.m2   <= req.partner_mass;
            s1_reg.msum <= 32'(req.own_mass) + 32'(req.partner_mass);
            s1_reg.span <= req.center_distance;
            s1_reg.vx   <= req.own_vel_x;
            s1_reg.vy   <= req.own_vel_y;
            s1_reg.wx   <= req.other_vel_x;
            s1_reg.wy   <= req.other_vel_y;
            s1_reg.deg  <= (req.center_distance == '0) ||
                           (req.own_mass == '0 && req.partner_mass == '0);
        end
    end

    // divider setup: magnitude numerators; the upper word starts as remainder,
    // and a quotient of 2^32 or more shows up as an upper word not below the divisor
    always_comb
    begin
        mag_x = s1_reg.dx[32] ? 33'(-s1_reg.dx) : 33'(s1_reg.dx);
        mag_y = s1_reg.dy[32] ? 33'(-s1_reg.dy) : 33'(s1_reg.dy);
        mag_a = s1_reg.dm[31] ? 31'(-s1_reg.dm) : 31'(s1_reg.dm);

        init_x.rem = {1'b0, mag_x[32:2]};
        init_x.num = {mag_x[1:0], 30'd0};
        init_x.den = {1'b0, s1_reg.span};

        init_y.rem = {1'b0, mag_y[32:2]};
        init_y.num = {mag_y[1:0], 30'd0};
        init_y.den = {1'b0, s1_reg.span};

        // mass fraction a in q2.29
        init_a.rem = {4'd0, mag_a[30:3]};
        init_a.num = {mag_a[2:0], 29'd0};
        init_a.den = s1_reg.msum;

        // mass fraction b = 2*m2/msum in q2.29
        init_b.rem = {3'd0, s1_reg.m2[30:2]};
        init_b.num = {s1_reg.m2[1:0], 30'd0};
        init_b.den = s1_reg.msum;

        side_in.vx    = s1_reg.vx;
        side_in.vy    = s1_reg.vy;
        side_in.wx    = s1_reg.wx;
        side_in.wy    = s1_reg.wy;
        side_in.neg_x = s1_reg.dx[32];
        side_in.neg_y = s1_reg.dy[32];
        side_in.neg_a = s1_reg.dm[31];
        side_in.ovf_x = init_x.rem >= init_x.den;
        side_in.ovf_y = init_y.rem >= init_y.den;
        side_in.deg   = s1_reg.deg;
    end

    decv_div_lane u_div_x (.clk(clk), .en(en), .init(init_x), .quo(qx));
    decv_div_lane u_div_y (.clk(clk), .en(en), .init(init_y), .quo(qy));
    decv_div_lane u_div_a (.clk(clk), .en(en), .init(init_a), .quo(qa));
    decv_div_lane u_div_b (.clk(clk), .en(en), .init(init_b), .quo(qb));

    // sideband and valid line matching the divider depth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DIV_STEPS-2:0], s1_vld_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 1; k < DIV_STEPS; k++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    decv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .vld       (vld_reg[DIV_STEPS-1]),
        .side      (side_reg[DIV_STEPS-1]),
        .qx        (qx),
        .qy        (qy),
        .qa        (qa),
        .qb        (qb),
        .damping   (damping_reg),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule
